FILE: rtl/core/slms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_pkg
// Shared types, residue codes and helpers for the liability motif scanner.
// ----------------------------------------------------------------------------
package slms_pkg;

    // Longest run that the position counter follows before it saturates.
    localparam int MAX_LEN = 256;
    localparam int COUNT_W = $clog2(MAX_LEN + 1);

    // Findings that one item can leave in the result queue.
    localparam int NUM_SLOTS = 6;

    localparam logic [1:0] CHAIN_UNSUPPORTED = 2'd3;

    // One-letter amino acid codes in ASCII.
    localparam logic [7:0] RES_A = 8'h41;
    localparam logic [7:0] RES_C = 8'h43;
    localparam logic [7:0] RES_D = 8'h44;
    localparam logic [7:0] RES_G = 8'h47;
    localparam logic [7:0] RES_H = 8'h48;
    localparam logic [7:0] RES_K = 8'h4B;
    localparam logic [7:0] RES_M = 8'h4D;
    localparam logic [7:0] RES_N = 8'h4E;
    localparam logic [7:0] RES_P = 8'h50;
    localparam logic [7:0] RES_S = 8'h53;
    localparam logic [7:0] RES_T = 8'h54;
    localparam logic [7:0] RES_W = 8'h57;

    // Conserved cysteine numbers.
    localparam logic [7:0] CYS_NUM_FIRST  = 8'd23;
    localparam logic [7:0] CYS_NUM_SECOND = 8'd104;

    localparam logic [1:0] SPAN_MARKER = 2'd0;
    localparam logic [1:0] SPAN_SINGLE = 2'd1;
    localparam logic [1:0] SPAN_PAIR   = 2'd2;
    localparam logic [1:0] SPAN_TRIPLE = 2'd3;

    typedef enum logic [3:0] {
        KIND_NONE       = 4'd0,
        KIND_OXIDATION  = 4'd1,
        KIND_TS         = 4'd2,
        KIND_DEAMID_LOW = 4'd3,
        KIND_NDP        = 4'd4,
        KIND_ISOMER     = 4'd5,
        KIND_DEAMID_HI  = 4'd6,
        KIND_DEAMID_MOD = 4'd7,
        KIND_GLYCO      = 4'd8,
        KIND_CYS        = 4'd9,
        KIND_BAD_CHAIN  = 4'd10
    } kind_t;

    typedef struct packed {
        logic [7:0] start_index;
        logic [1:0] span_length;
        kind_t      liability_kind;
    } finding_t;

    // One residue as the window keeps it.
    typedef struct packed {
        logic [7:0] residue;
        logic       scanned;
        logic       in_cdr;
        logic       cys_ok;
    } entry_t;

    // Findings of one judged residue: the CDR single/pair motif and the
    // three-residue motif (glycosylation or cysteine).
    typedef struct packed {
        logic     pair_valid;
        finding_t pair;
        logic     extra_valid;
        finding_t extra;
    } judge_out_t;

    // Everything one item hands to the result queue.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        finding_t [NUM_SLOTS-1:0] slot;
        logic last;
    } result_set_t;

    function automatic logic [7:0] sat_index(input logic [COUNT_W-1:0] v);
        logic [7:0] r;
        if (32'(v) > 32'd255) begin
            r = 8'hFF;
        end else begin
            r = 8'(v);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/slms_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_judge
// Motif checks for one residue against the residues that follow it.
// ----------------------------------------------------------------------------
module slms_judge (
    input  slms_pkg::entry_t     entry,
    input  logic                 has1,
    input  logic [7:0]           r1,
    input  logic                 has2,
    input  logic [7:0]           r2,
    input  logic [7:0]           start_index,
    output slms_pkg::judge_out_t result
);

    logic [7:0]     r0;
    logic           pair_hit;
    logic [1:0]     pair_span;
    slms_pkg::kind_t pair_kind;
    logic           glyco_hit;
    logic           cys_hit;

    assign r0 = entry.residue;

    // The CDR motifs are mutually exclusive, so one slot is enough.
    always_comb begin
        pair_hit  = 1'b0;
        pair_span = slms_pkg::SPAN_PAIR;
        pair_kind = slms_pkg::KIND_NONE;
        if (entry.scanned && entry.in_cdr) begin
            if (r0 == slms_pkg::RES_M || r0 == slms_pkg::RES_W) begin
                pair_hit  = 1'b1;
                pair_span = slms_pkg::SPAN_SINGLE;
                pair_kind = slms_pkg::KIND_OXIDATION;
            end else if (has1) begin
                if (r0 == slms_pkg::RES_T && r1 == slms_pkg::RES_S) begin
                    pair_hit  = 1'b1;
                    pair_kind = slms_pkg::KIND_TS;
                end else if (r1 == slms_pkg::RES_N && (r0 == slms_pkg::RES_S ||
                             r0 == slms_pkg::RES_T || r0 == slms_pkg::RES_K)) begin
                    pair_hit  = 1'b1;
                    pair_kind = slms_pkg::KIND_DEAMID_LOW;
                end else if ((r0 == slms_pkg::RES_N || r0 == slms_pkg::RES_D) &&
                             r1 == slms_pkg::RES_P) begin
                    pair_hit  = 1'b1;
                    pair_kind = slms_pkg::KIND_NDP;
                end else if (r0 == slms_pkg::RES_D && (r1 == slms_pkg::RES_D ||
                             r1 == slms_pkg::RES_G || r1 == slms_pkg::RES_H ||
                             r1 == slms_pkg::RES_S || r1 == slms_pkg::RES_T)) begin
                    pair_hit  = 1'b1;
                    pair_kind = slms_pkg::KIND_ISOMER;
                end else if (r0 == slms_pkg::RES_N && (r1 == slms_pkg::RES_G ||
                             r1 == slms_pkg::RES_S)) begin
                    pair_hit  = 1'b1;
                    pair_kind = slms_pkg::KIND_DEAMID_HI;
                end else if (r0 == slms_pkg::RES_N && (r1 == slms_pkg::RES_A ||
                             r1 == slms_pkg::RES_H || r1 == slms_pkg::RES_N ||
                             r1 == slms_pkg::RES_T)) begin
                    pair_hit  = 1'b1;
                    pair_kind = slms_pkg::KIND_DEAMID_MOD;
                end
            end
        end
    end

    assign glyco_hit = entry.scanned && has2 && r0 == slms_pkg::RES_N &&
                       r1 != slms_pkg::RES_P &&
                       (r2 == slms_pkg::RES_S || r2 == slms_pkg::RES_T);
    assign cys_hit   = entry.scanned && r0 == slms_pkg::RES_C && !entry.cys_ok;

    always_comb begin
        result.pair_valid                = pair_hit;
        result.pair.start_index          = start_index;
        result.pair.span_length          = pair_span;
        result.pair.liability_kind       = pair_kind;
        result.extra_valid               = glyco_hit || cys_hit;
        result.extra.start_index         = start_index;
        result.extra.span_length         = slms_pkg::SPAN_TRIPLE;
        result.extra.liability_kind      = glyco_hit ? slms_pkg::KIND_GLYCO
                                                     : slms_pkg::KIND_CYS;
    end

endmodule

FILE: rtl/core/slms_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_result_queue
// Result register holding one item's findings, sent out one per transaction.
// ----------------------------------------------------------------------------
module slms_result_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  slms_pkg::result_set_t set_in,
    output logic                  load_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output slms_pkg::finding_t    out_finding,
    output logic                  out_last
);

    logic [slms_pkg::NUM_SLOTS-1:0]       mask_reg;
    logic [slms_pkg::NUM_SLOTS-1:0]       mask_next;
    slms_pkg::finding_t [slms_pkg::NUM_SLOTS-1:0] slot_reg;
    logic                                 last_reg;
    logic [slms_pkg::NUM_SLOTS-1:0]       head;
    logic [slms_pkg::NUM_SLOTS-1:0]       mask_after;
    logic                                 taken;

    // Lowest pending slot goes out first; slots are in file order.
    assign head       = mask_reg & (~mask_reg + slms_pkg::NUM_SLOTS'(1));
    assign out_valid  = |mask_reg;
    assign taken      = out_valid && out_ready;
    assign mask_after = taken ? (mask_reg & ~head) : mask_reg;
    assign load_ready = (mask_after == '0);
    assign out_last   = last_reg && ((mask_reg & ~head) == '0);

    always_comb begin
        out_finding = '0;
        for (int i = 0; i < slms_pkg::NUM_SLOTS; i++) begin
            if (head[i]) begin
                out_finding = out_finding | slot_reg[i];
            end
        end
    end

    assign mask_next = (load && load_ready) ? set_in.mask : mask_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            slot_reg <= set_in.slot;
            last_reg <= set_in.last;
        end
    end

endmodule

FILE: rtl/core/sequence_liability_motif_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_liability_motif_scanner
// Streaming scan of antibody residues for chemical liability motifs.
// ----------------------------------------------------------------------------
// Path: an accepted residue passes the input register, then the result
// register, before its first finding can leave.
// Throughput: one residue per cycle while each residue yields at most one
// finding and m_tready is high; a residue with several findings holds the
// result register until all are out; the port moves one finding per cycle.
// Reset: aresetn is synchronous and active low; it empties both registers,
// clears the window and the position counter and sets chain_kind to heavy.
// ----------------------------------------------------------------------------
module sequence_liability_motif_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: chain_kind.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // Residue stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] residue, [8] scanned, [9] in_cdr, [17:10] number_position,
    // [18] has_insertion, [23:19] zero.
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,     // seq_end
    // Findings stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] start_index, [9:8] span_length, [15:10] zero.
    output logic [15:0] m_tdata,
    // [3:0] liability_kind.
    output logic [3:0]  m_tuser,
    output logic        m_tlast      // final_of_sequence
);

    // The input register holds one accepted residue until the result register
    // can take its findings. The window and counter describe the residues
    // before it and advance only when that residue is processed.
    logic                          in_valid_reg;
    logic [23:0]                   in_data_reg;
    logic                          in_end_reg;
    logic [1:0]                    chain_kind_reg;
    slms_pkg::entry_t [1:0]        win_reg;
    logic [slms_pkg::COUNT_W-1:0]  count_reg;

    logic                          accept;
    logic                          process;
    logic                          load_ready;
    slms_pkg::entry_t              cur;
    logic                          bad_chain;
    logic                          has_w0;
    logic                          has_w1;
    logic                          en0;
    logic                          en1;
    logic                          en2;
    slms_pkg::judge_out_t          j0;
    slms_pkg::judge_out_t          j1;
    slms_pkg::judge_out_t          j2;
    slms_pkg::result_set_t         set;
    slms_pkg::finding_t            out_finding;
    logic [7:0]                    idx0;
    logic [7:0]                    idx1;
    logic [7:0]                    idx2;

    assign s_tready = !in_valid_reg || load_ready;
    assign accept   = s_tvalid && s_tready;
    assign process  = in_valid_reg && load_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_data_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_kind_reg <= 2'd0;
        end else if (cfg_we) begin
            chain_kind_reg <= cfg_wdata;
        end
    end

    // A cysteine is expected at positions 23 and 104 when no insertion letter
    // is attached to the number.
    always_comb begin
        cur.residue = in_data_reg[7:0];
        cur.scanned = in_data_reg[8];
        cur.in_cdr  = in_data_reg[9];
        cur.cys_ok  = !in_data_reg[18] &&
                      (in_data_reg[17:10] == slms_pkg::CYS_NUM_FIRST ||
                       in_data_reg[17:10] == slms_pkg::CYS_NUM_SECOND);
    end

    assign bad_chain = (chain_kind_reg == slms_pkg::CHAIN_UNSUPPORTED);
    assign has_w0    = (count_reg >= slms_pkg::COUNT_W'(2));
    assign has_w1    = (count_reg != '0);

    // The oldest window entry is judged on every residue once both of its
    // followers exist. At the end of a sequence the younger entry and the
    // current residue are judged too, with only the followers that exist.
    assign en0 = has_w0 && !bad_chain;
    assign en1 = in_end_reg && has_w1 && !bad_chain;
    assign en2 = in_end_reg && !bad_chain;

    assign idx0 = slms_pkg::sat_index(count_reg - slms_pkg::COUNT_W'(2));
    assign idx1 = slms_pkg::sat_index(count_reg - slms_pkg::COUNT_W'(1));
    assign idx2 = slms_pkg::sat_index(count_reg);

    slms_judge u_judge_oldest (
        .entry       (win_reg[0]),
        .has1        (1'b1),
        .r1          (win_reg[1].residue),
        .has2        (1'b1),
        .r2          (cur.residue),
        .start_index (idx0),
        .result      (j0)
    );

    slms_judge u_judge_middle (
        .entry       (win_reg[1]),
        .has1        (1'b1),
        .r1          (cur.residue),
        .has2        (1'b0),
        .r2          (8'd0),
        .start_index (idx1),
        .result      (j1)
    );

    slms_judge u_judge_current (
        .entry       (cur),
        .has1        (1'b0),
        .r1          (8'd0),
        .has2        (1'b0),
        .r2          (8'd0),
        .start_index (idx2),
        .result      (j2)
    );

    // Slots are laid out in file order: per residue its motif finding and
    // then its three-residue finding. An unsupported chain reports a single
    // error at the end; a sequence without findings ends with a marker.
    always_comb begin
        set.slot[0] = j0.pair;
        set.slot[1] = j0.extra;
        set.slot[2] = j1.pair;
        set.slot[3] = j1.extra;
        set.slot[4] = j2.pair;
        set.slot[5] = j2.extra;
        set.mask    = {j2.extra_valid && en2, j2.pair_valid && en2,
                       j1.extra_valid && en1, j1.pair_valid && en1,
                       j0.extra_valid && en0, j0.pair_valid && en0};
        set.last    = in_end_reg;
        if (in_end_reg && bad_chain) begin
            set.mask                   = slms_pkg::NUM_SLOTS'(1);
            set.slot[0].start_index    = 8'd0;
            set.slot[0].span_length    = slms_pkg::SPAN_MARKER;
            set.slot[0].liability_kind = slms_pkg::KIND_BAD_CHAIN;
        end else if (in_end_reg && set.mask == '0) begin
            set.mask                   = slms_pkg::NUM_SLOTS'(1);
            set.slot[0].start_index    = idx2;
            set.slot[0].span_length    = slms_pkg::SPAN_MARKER;
            set.slot[0].liability_kind = slms_pkg::KIND_NONE;
        end
    end

    // The window shifts on every processed residue but a sequence end, also for
    // an unsupported chain, and returns to its reset state at a sequence end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            count_reg <= '0;
        end else if (process) begin
            if (in_end_reg) begin
                win_reg   <= '0;
                count_reg <= '0;
            end else begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= cur;
                if (32'(count_reg) < slms_pkg::MAX_LEN) begin
                    count_reg <= count_reg + slms_pkg::COUNT_W'(1);
                end
            end
        end
    end

    slms_result_queue u_result_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (process),
        .set_in      (set),
        .load_ready  (load_ready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_finding (out_finding),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, out_finding.span_length, out_finding.start_index};
    assign m_tuser = out_finding.liability_kind;

endmodule

FILE: test/slms_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_tb_pkg
// Residue item type and finding scoreboard for the liability scanner bench.
// ----------------------------------------------------------------------------
package slms_tb_pkg;

    import slms_pkg::*;

    // One residue as the bench builds it before packing onto the stream.
    typedef struct packed {
        logic [7:0] residue;
        logic       scanned;
        logic       in_cdr;
        logic [7:0] number_position;
        logic       has_insertion;
        logic       seq_end;
    } residue_item_t;

    // One finding as it should leave the block.
    typedef struct {
        logic [7:0] start_index;
        logic [1:0] span_length;
        kind_t      liability_kind;
        logic       final_of_sequence;
    } liability_t;

    class liability_scoreboard;
        logic [1:0]  chain_kind;
        entry_t      window[2];
        int unsigned position_count;
        liability_t  awaited_findings[$];
        int          errors;
        int          findings_checked;
        logic [15:0] kinds_seen;

        function new();
            chain_kind = 2'd0;
            window[0] = '0;
            window[1] = '0;
            position_count = 0;
            errors = 0;
            findings_checked = 0;
            kinds_seen = '0;
        endfunction

        function void set_chain(input logic [1:0] value);
            chain_kind = value;
        endfunction

        function int outstanding();
            return awaited_findings.size();
        endfunction

        function void add_finding(input int unsigned idx, input logic [1:0] span,
                                  input kind_t kind);
            liability_t f;
            f.start_index = (idx > 255) ? 8'hFF : 8'(idx);
            f.span_length = span;
            f.liability_kind = kind;
            f.final_of_sequence = 1'b0;
            awaited_findings.insert(awaited_findings.size(), f);
        endfunction

        // Judges one residue against the residues that follow it, if any.
        function void judge_residue(input int unsigned idx, input entry_t e,
                                    input bit has1, input logic [7:0] r1,
                                    input bit has2, input logic [7:0] r2);
            if (!e.scanned) return;
            if (e.in_cdr) begin
                // Oxidation hides every other CDR motif at this residue.
                if (e.residue == RES_M || e.residue == RES_W) begin
                    add_finding(idx, SPAN_SINGLE, KIND_OXIDATION);
                    return;
                end
                if (has1) begin
                    if (e.residue == RES_T && r1 == RES_S) begin
                        add_finding(idx, SPAN_PAIR, KIND_TS);
                        return;
                    end
                    if (r1 == RES_N && (e.residue == RES_S || e.residue == RES_T ||
                                        e.residue == RES_K))
                        add_finding(idx, SPAN_PAIR, KIND_DEAMID_LOW);
                    if ((e.residue == RES_N || e.residue == RES_D) && r1 == RES_P)
                        add_finding(idx, SPAN_PAIR, KIND_NDP);
                    if (e.residue == RES_D && (r1 == RES_D || r1 == RES_G || r1 == RES_H ||
                                               r1 == RES_S || r1 == RES_T))
                        add_finding(idx, SPAN_PAIR, KIND_ISOMER);
                    if (e.residue == RES_N && (r1 == RES_G || r1 == RES_S))
                        add_finding(idx, SPAN_PAIR, KIND_DEAMID_HI);
                    if (e.residue == RES_N && (r1 == RES_A || r1 == RES_H ||
                                               r1 == RES_N || r1 == RES_T))
                        add_finding(idx, SPAN_PAIR, KIND_DEAMID_MOD);
                end
            end
            if (has2 && e.residue == RES_N && r1 != RES_P && (r2 == RES_S || r2 == RES_T))
                add_finding(idx, SPAN_TRIPLE, KIND_GLYCO);
            if (e.residue == RES_C && !e.cys_ok)
                add_finding(idx, SPAN_TRIPLE, KIND_CYS);
        endfunction

        // Works out the findings of one accepted residue and advances the window.
        function void note_residue(input residue_item_t it);
            entry_t      cur;
            entry_t      trio[3];
            int unsigned n, prev, k, j, first;
            cur.residue = it.residue;
            cur.scanned = it.scanned;
            cur.in_cdr = it.in_cdr;
            cur.cys_ok = !it.has_insertion && (it.number_position == CYS_NUM_FIRST ||
                                               it.number_position == CYS_NUM_SECOND);
            n = position_count;
            prev = (n < 2) ? n : 2;
            k = prev + 1;
            for (j = 0; j < prev; j++) trio[j] = window[2 - prev + j];
            trio[prev] = cur;
            first = awaited_findings.size();

            if (chain_kind == CHAIN_UNSUPPORTED) begin
                if (it.seq_end) begin
                    add_finding(0, SPAN_MARKER, KIND_BAD_CHAIN);
                end
            end else if (it.seq_end) begin
                // Flush: each remaining residue sees only the residues that exist.
                for (j = 0; j < k; j++) begin
                    judge_residue(n - (k - 1 - j), trio[j],
                                  (j + 1 < k), (j + 1 < k) ? trio[j + 1].residue : 8'h00,
                                  (j + 2 < k), (j + 2 < k) ? trio[j + 2].residue : 8'h00);
                end
                if (awaited_findings.size() == first)
                    add_finding(n, SPAN_MARKER, KIND_NONE);
            end else if (k == 3) begin
                judge_residue(n - 2, trio[0], 1'b1, trio[1].residue, 1'b1, trio[2].residue);
            end

            if (it.seq_end) begin
                awaited_findings[awaited_findings.size() - 1].final_of_sequence = 1'b1;
                window[0] = '0;
                window[1] = '0;
                position_count = 0;
            end else begin
                window[0] = window[1];
                window[1] = cur;
                if (position_count < MAX_LEN) position_count++;
            end
        endfunction

        // Compares one accepted finding with the oldest one still awaited.
        function void check_finding(input logic [15:0] data, input logic [3:0] kind,
                                    input logic last);
            liability_t f;
            bit         bad;
            if (awaited_findings.size() == 0) begin
                $display("%0t: unexpected finding start=%0d span=%0d kind=%0d last=%0b",
                         $time, data[7:0], data[9:8], kind, last);
                errors++;
                return;
            end
            f = awaited_findings.pop_front();
            bad = 1'b0;
            if (data[7:0] !== f.start_index) begin
                $display("%0t: start_index mismatch: expected %0d, actual %0d",
                         $time, f.start_index, data[7:0]);
                bad = 1'b1;
            end
            if (data[9:8] !== f.span_length) begin
                $display("%0t: span_length mismatch: expected %0d, actual %0d",
                         $time, f.span_length, data[9:8]);
                bad = 1'b1;
            end
            if (kind !== 4'(f.liability_kind)) begin
                $display("%0t: liability_kind mismatch: expected %0d (%s), actual %0d",
                         $time, f.liability_kind, f.liability_kind.name(), kind);
                bad = 1'b1;
            end
            if (last !== f.final_of_sequence) begin
                $display("%0t: final_of_sequence mismatch: expected %0b, actual %0b",
                         $time, f.final_of_sequence, last);
                bad = 1'b1;
            end
            if (bad) errors++;
            else kinds_seen[f.liability_kind] = 1'b1;
            findings_checked++;
        endfunction
    endclass

endpackage

FILE: test/sequence_liability_motif_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_liability_motif_scanner_tb
// Self-checking bench for the liability motif scanner. Residues are streamed
// in as directed motif strings and then as random runs under every chain
// setting; a scoreboard predicts each finding and checks the result stream in
// order, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module sequence_liability_motif_scanner_tb;

    import slms_pkg::*;
    import slms_tb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // residue, scanned, in_cdr, number_position, has_insertion
    logic        s_tlast;     // seq_end
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // start_index, span_length
    logic [3:0]  m_tuser;     // liability_kind
    logic        m_tlast;     // final_of_sequence

    liability_scoreboard sb;

    // Gap switches let whole stretches run back to back on either side.
    bit src_gaps_on;
    bit sink_gaps_on;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit sink_hold;
    int residues_sent;
    int sequences_sent;

    sequence_liability_motif_scanner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic residue_item_t make_residue(input logic [7:0] r, input logic sc,
                                                   input logic cdr, input logic [7:0] num,
                                                   input logic ins, input logic last);
        residue_item_t it;
        it.residue = r;
        it.scanned = sc;
        it.in_cdr = cdr;
        it.number_position = num;
        it.has_insertion = ins;
        it.seq_end = last;
        return it;
    endfunction

    // Mostly letters that take part in some motif, with some arbitrary codes
    // mixed in as noise. Cysteine numbers hit the conserved ones often.
    function automatic residue_item_t random_residue(input logic cdr);
        residue_item_t it;
        logic [7:0] motif_letters[12];
        motif_letters = '{RES_M, RES_W, RES_T, RES_S, RES_K, RES_N,
                          RES_D, RES_P, RES_G, RES_H, RES_A, RES_C};
        if ($urandom_range(0, 7) != 0) begin
            it.residue = motif_letters[$urandom_range(0, 11)];
        end else begin
            it.residue = 8'($urandom_range(0, 255));
        end
        it.scanned = ($urandom_range(0, 7) != 0);
        it.in_cdr = cdr;
        case ($urandom_range(0, 3))
            0: it.number_position = CYS_NUM_FIRST;
            1: it.number_position = CYS_NUM_SECOND;
            default: it.number_position = 8'($urandom_range(0, 255));
        endcase
        it.has_insertion = ($urandom_range(0, 4) == 0);
        it.seq_end = 1'b0;
        return it;
    endfunction

    // Offers one residue after a random gap and waits for the transaction.
    task automatic send_residue(input residue_item_t it);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {5'b0, it.has_insertion, it.number_position, it.in_cdr, it.scanned,
                   it.residue};
        s_tlast = it.seq_end;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_residue(it);
        residues_sent++;
        if (it.seq_end) sequences_sent++;
    endtask

    // A whole scanned sequence spelled out as letters; numbering follows the index.
    task automatic send_word(input string w, input logic cdr);
        int i;
        for (i = 0; i < w.len(); i++) begin
            send_residue(make_residue(w[i], 1'b1, cdr, 8'(i), 1'b0, i == w.len() - 1));
        end
    endtask

    // Short random sequences with CDR stretches. When close_last is clear the
    // final sequence is left open so a chain change lands mid-sequence.
    task automatic send_random_runs(input int n_items, input bit close_last);
        int sent, len, i;
        logic cdr;
        residue_item_t it;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
            if (len > n_items - sent) len = n_items - sent;
            src_gaps_on = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            cdr = $urandom_range(0, 1);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 4) == 0) cdr = !cdr;
                it = random_residue(cdr);
                it.seq_end = (i == len - 1) && (close_last || sent + len < n_items);
                send_residue(it);
            end
            sent += len;
        end
    endtask

    // The sender stops offering before the wait, so the last residue is not
    // taken a second time.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // The chain register is written only when no finding is outstanding. A
    // residue may still sit in the pipeline without a finding, so the task waits
    // on past the drain before the write.
    task automatic write_chain(input logic [1:0] value);
        wait_drained();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.set_chain(value);
    endtask

    // Result side: random stall before each finding, or one long hold-off
    // when the stimulus asks for it.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        m_tready = 1'b1;
        forever begin
            stall = sink_gaps_on ? $urandom_range(0, 5) : 0;
            if (sink_hold) begin
                stall = 200;
                sink_hold = 1'b0;
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
                m_tready = 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
            sb.check_finding(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin
        int i;
        residue_item_t it;
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        sink_hold = 1'b0;
        residues_sent = 0;
        sequences_sent = 0;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part on a heavy chain.
        write_chain(2'd0);
        // Every CDR motif: oxidation, TS, KN, NP, DH, NG, NT, TN and NA at the flush.
        send_word("WTSKNPDHNGNTNA", 1'b1);
        // Framework: glycosylation, conserved cysteines, one with an insertion,
        // and a cysteine on the last residue that still reports a span of three.
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        send_residue(make_residue(RES_N, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0));
        send_residue(make_residue(RES_A, 1'b1, 1'b0, 8'd1, 1'b0, 1'b0));
        send_residue(make_residue(RES_S, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0));
        send_residue(make_residue(RES_C, 1'b1, 1'b0, CYS_NUM_FIRST, 1'b0, 1'b0));
        send_residue(make_residue(RES_C, 1'b1, 1'b0, CYS_NUM_SECOND, 1'b1, 1'b0));
        send_residue(make_residue(RES_C, 1'b1, 1'b0, 8'hFF, 1'b0, 1'b1));
        // Single residue sequences with nothing to report end in a marker, around an NS sequence.
        send_residue(make_residue(8'hFF, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1));
        send_word("NS", 1'b1);
        send_residue(make_residue(RES_M, 1'b0, 1'b1, 8'd7, 1'b0, 1'b1));

        // Kappa: first a dense run of NG pairs while the receiver holds off,
        // so the block backs up and stalls its input.
        write_chain(2'd1);
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        sink_hold = 1'b1;
        for (i = 0; i < 30; i++) begin
            send_residue(make_residue((i % 2) ? RES_G : RES_N, 1'b1, 1'b1, 8'(i), 1'b0,
                                      i == 29));
        end
        // The sender pauses here until every finding has come out.
        wait_drained();
        send_random_runs(40, 1'b1);

        // Lambda, with the last sequence left open across the chain change.
        write_chain(2'd2);
        send_random_runs(40, 1'b0);

        // Unsupported chain: only one error per sequence end.
        write_chain(CHAIN_UNSUPPORTED);
        send_random_runs(30, 1'b0);

        // Back to heavy, including one sequence past the counter saturation.
        write_chain(2'd0);
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        for (i = 0; i < 260; i++) begin
            if (i == 100) src_gaps_on = 1'b0;
            it = random_residue((i % 40) < 15);
            it.seq_end = (i == 259);
            send_residue(it);
        end
        send_random_runs(20, 1'b1);

        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Covered %0d residues in %0d sequences over all four chain settings.",
                 residues_sent, sequences_sent);
        $display("Checked %0d findings; %0d distinct liability kinds seen.",
                 sb.findings_checked, $countones(sb.kinds_seen));
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/slms_pkg.sv
rtl/core/slms_judge.sv
rtl/core/slms_result_queue.sv
rtl/core/sequence_liability_motif_scanner.sv
test/slms_tb_pkg.sv
test/sequence_liability_motif_scanner_tb.sv
